>>> design/mprc_pkg.sv
// Shared types and constants of the motor PWM ramp controller.
package mprc_pkg;

	localparam int DUTY_W    = 7;
	localparam int TIME_W    = 32;
	localparam int RELOAD_W  = 16;
	localparam int RATE_W    = 8;
	localparam int FRATE_W   = 11;               // ramp_rate * 5 fits in 11 bits
	localparam int TPROD_W   = FRATE_W + TIME_W; // full ramp product, no wrap
	localparam int SPROD_W   = RELOAD_W + DUTY_W;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [DUTY_W-1:0] SPEED_KNEE = 7'd25;
	localparam logic [DUTY_W-1:0] PERCENT    = 7'd100;
	localparam logic [3:0]        TIME_DIV   = 4'd10;

	// x / 10 == (x * 1639) >> 14 for x < 2720
	localparam int                DIV10_SH  = 14;
	localparam logic [10:0]       DIV10_MUL = 11'd1639;
	// x / 100 == (x * 10737419) >> 30 for quotients below 141281
	localparam int                DIV100_SH  = 30;
	localparam logic [23:0]       DIV100_MUL = 24'd10737419;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_REVERSED = 2'd0;
	localparam cfg_idx_t REG_RELOAD   = 2'd1;
	localparam cfg_idx_t REG_RATE     = 2'd2;
	localparam cfg_idx_t REG_DUTY_MAX = 2'd3;

	localparam logic [RELOAD_W-1:0] RELOAD_RST   = 16'hFFFF;
	localparam logic [RATE_W-1:0]   RATE_RST     = 8'd1;
	localparam logic [DUTY_W-1:0]   DUTY_MAX_RST = 7'd100;

	typedef enum logic {
		ACT_SET    = 1'b0,
		ACT_UPDATE = 1'b1
	} action_t;

	typedef struct packed {
		logic                reversed_wiring;
		logic [RELOAD_W-1:0] timer_reload;
		logic [RATE_W-1:0]   ramp_rate;
		logic [DUTY_W-1:0]   duty_max;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input word
		logic apply_set; // store new target and ramp start
		logic clear_res; // result with nothing driven
		logic mul;       // ramp product
		logic step;      // divide, clamp, update duty
		logic adjust;    // pin, adjusted duty, reload product
		logic scale;     // divide by 100, saturate
		logic emit;      // move result to output register
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_set;
		logic at_goal;
		logic slot_free;
	} ctl_sts_t;

endpackage

>>> design/mprc_if.sv
// Handshake interfaces for the input and result channels.
interface mprc_in_if;
	import mprc_pkg::*;
	logic                valid;
	logic                ready;
	logic                action;
	logic                direction;
	logic [DUTY_W-1:0]   target_duty;
	logic [TIME_W-1:0]   now_ms;

	modport source (output valid, action, direction, target_duty, now_ms, input ready);
	modport sink (input valid, action, direction, target_duty, now_ms, output ready);
endinterface

interface mprc_out_if;
	import mprc_pkg::*;
	logic                valid;
	logic                ready;
	logic                drive_valid;
	logic                direction_pin;
	logic                compare_valid;
	logic [RELOAD_W-1:0] compare_value;
	logic [DUTY_W-1:0]   current_duty;

	modport source (output valid, drive_valid, direction_pin, compare_valid, compare_value,
		current_duty, input ready);
	modport sink (input valid, drive_valid, direction_pin, compare_valid, compare_value,
		current_duty, output ready);
endinterface

>>> design/motor_pwm_ramp_controller.sv
// Top level of the motor PWM ramp controller.
//
//  channel  dir  handshake        word
//  item     in   valid/ready      action, direction, target_duty, now_ms
//  result   out  valid/ready      drive_valid, direction_pin, compare_valid,
//                                 compare_value, current_duty
//  cfg      in   cfg_we only      cfg_index, cfg_data (no read-back)
//
// One word is in flight at a time. A set word or an update already at target
// goes from capture and decide straight to the result register; a ramp update
// passes through capture, decide, ramp multiply, divide by ten and clamp, reload
// multiply, divide by 100 and output. The next word is accepted the cycle after
// the result is registered, even while it waits; a stalled result holds the
// sequencer in its last step. arst_n zeroes ramp state and loads register defaults.
module motor_pwm_ramp_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	mprc_in_if.sink                         item,
	mprc_out_if.source                      result,
	input  logic                            cfg_we,
	input  mprc_pkg::cfg_idx_t              cfg_index,
	input  logic [mprc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mprc_pkg::*;

	cfg_t     cfg;
	ctl_cmd_t cmd;
	ctl_sts_t sts;

	// register file
	mprc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer: owns item.ready
	mprc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// ramp state, arithmetic and output register
	mprc_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg               (cfg),
		.in_action         (item.action),
		.in_direction      (item.direction),
		.in_target_duty    (item.target_duty),
		.in_now_ms         (item.now_ms),
		.out_ready         (result.ready),
		.out_valid         (result.valid),
		.out_drive_valid   (result.drive_valid),
		.out_direction_pin (result.direction_pin),
		.out_compare_valid (result.compare_valid),
		.out_compare_value (result.compare_value),
		.out_current_duty  (result.current_duty)
	);

endmodule

>>> design/mprc_cfg.sv
// Configuration register file.
module mprc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  mprc_pkg::cfg_idx_t              cfg_index,
	input  logic [mprc_pkg::CFG_DATA_W-1:0] cfg_data,
	output mprc_pkg::cfg_t                  cfg
);
	import mprc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reversed_wiring <= 1'b0;
			cfg_q.timer_reload    <= RELOAD_RST;
			cfg_q.ramp_rate       <= RATE_RST;
			cfg_q.duty_max        <= DUTY_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_REVERSED: cfg_q.reversed_wiring <= cfg_data[0];
				REG_RELOAD:   cfg_q.timer_reload    <= cfg_data[RELOAD_W-1:0];
				REG_RATE:     cfg_q.ramp_rate       <= cfg_data[RATE_W-1:0];
				REG_DUTY_MAX: cfg_q.duty_max        <= cfg_data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/mprc_ctrl.sv
// Sequencing state machine: one word at a time through the datapath steps.
module mprc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mprc_pkg::ctl_sts_t sts,
	output mprc_pkg::ctl_cmd_t cmd
);
	import mprc_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_EVAL  = 7'b0000010,
		ST_MUL   = 7'b0000100,
		ST_DIV   = 7'b0001000,
		ST_ADJ   = 7'b0010000,
		ST_SCALE = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.is_set) begin
					cmd.apply_set = 1'b1;
					cmd.clear_res = 1'b1;
					state_d       = ST_DONE;
				end else if (sts.at_goal) begin
					cmd.clear_res = 1'b1;
					state_d       = ST_DONE;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				state_d  = ST_ADJ;
			end
			ST_ADJ: begin
				cmd.adjust = 1'b1;
				state_d    = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (sts.slot_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> design/mprc_dp.sv
// Ramp and PWM compare datapath with the output register.
module mprc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mprc_pkg::ctl_cmd_t            cmd,
	output mprc_pkg::ctl_sts_t            sts,
	input  mprc_pkg::cfg_t                cfg,
	input  logic                          in_action,
	input  logic                          in_direction,
	input  logic [mprc_pkg::DUTY_W-1:0]   in_target_duty,
	input  logic [mprc_pkg::TIME_W-1:0]   in_now_ms,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic                          out_drive_valid,
	output logic                          out_direction_pin,
	output logic                          out_compare_valid,
	output logic [mprc_pkg::RELOAD_W-1:0] out_compare_value,
	output logic [mprc_pkg::DUTY_W-1:0]   out_current_duty
);
	import mprc_pkg::*;

	// ramp state
	logic [DUTY_W-1:0]   present_q, goal_q, start_duty_q;
	logic                goal_dir_q;
	logic [TIME_W-1:0]   start_time_q;

	// captured word
	action_t             action_q;
	logic                dir_q;
	logic [DUTY_W-1:0]   tgt_q;
	logic [TIME_W-1:0]   now_q, elapsed_q;

	// work registers
	logic [TPROD_W-1:0]  tprod_q;
	logic [SPROD_W-1:0]  sprod_q;
	logic                withhold_q;
	logic                drive_q, pin_q, cvalid_q;
	logic [RELOAD_W-1:0] cval_q;

	// output register
	logic                out_valid_q;
	logic                o_drive_q, o_pin_q, o_cvalid_q;
	logic [RELOAD_W-1:0] o_cval_q;
	logic [DUTY_W-1:0]   o_duty_q;

	logic [FRATE_W-1:0]  rate;
	logic                reached;
	logic [DUTY_W-1:0]   gap;
	logic [FRATE_W-1:0]  gap_limit;
	logic [21:0]         small_prod;
	logic [DUTY_W:0]     next_duty;
	logic                inverted, neg;
	logic [DUTY_W-1:0]   adj;
	logic [46:0]         qprod;
	logic [16:0]         quot;

	// fast ramp: rate*5 as shift and add
	assign rate = (present_q > SPEED_KNEE)
		? ({1'b0, cfg.ramp_rate, 2'b00} + {3'b000, cfg.ramp_rate})
		: {3'b000, cfg.ramp_rate};

	// start + P/10 >= goal  <=>  start >= goal or P >= 10*(goal-start)
	assign gap        = goal_q - start_duty_q;
	assign gap_limit  = FRATE_W'(gap) * FRATE_W'(TIME_DIV);
	assign reached    = (start_duty_q >= goal_q) || (tprod_q >= TPROD_W'(gap_limit));
	// below the limit the product fits in 11 bits
	assign small_prod = 22'(tprod_q[FRATE_W-1:0]) * 22'(DIV10_MUL);
	assign next_duty  = {1'b0, start_duty_q} + {1'b0, small_prod[DIV10_SH +: DUTY_W]};

	// pin level and inversion coincide for both wirings
	assign inverted = cfg.reversed_wiring ? goal_dir_q : !goal_dir_q;
	assign neg      = inverted && (present_q > PERCENT);
	assign adj      = inverted ? (PERCENT - present_q) : present_q;

	assign qprod = 47'(sprod_q) * 47'(DIV100_MUL);
	assign quot  = qprod[DIV100_SH +: 17];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q    <= '0;
			goal_q       <= '0;
			goal_dir_q   <= 1'b0;
			start_time_q <= '0;
			start_duty_q <= '0;
		end else if (cmd.apply_set) begin
			goal_q       <= tgt_q;
			goal_dir_q   <= dir_q;
			start_time_q <= now_q;
			if (dir_q != goal_dir_q) begin
				present_q    <= '0;
				start_duty_q <= '0;
			end else begin
				start_duty_q <= present_q;
			end
		end else if (cmd.step) begin
			present_q <= reached ? goal_q : next_duty[DUTY_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q  <= action_t'(in_action);
			dir_q     <= in_direction;
			tgt_q     <= in_target_duty;
			now_q     <= in_now_ms;
			elapsed_q <= in_now_ms - start_time_q;
		end
		if (cmd.mul) begin
			tprod_q <= TPROD_W'(rate) * TPROD_W'(elapsed_q);
		end
		if (cmd.clear_res) begin
			drive_q  <= 1'b0;
			pin_q    <= 1'b0;
			cvalid_q <= 1'b0;
			cval_q   <= '0;
		end
		if (cmd.adjust) begin
			drive_q    <= 1'b1;
			pin_q      <= inverted;
			withhold_q <= neg || (adj > cfg.duty_max);
			sprod_q    <= SPROD_W'(cfg.timer_reload) * SPROD_W'(adj);
		end
		if (cmd.scale) begin
			cvalid_q <= !withhold_q;
			if (withhold_q) begin
				cval_q <= '0;
			end else begin
				cval_q <= quot[16] ? {RELOAD_W{1'b1}} : quot[RELOAD_W-1:0];
			end
		end
		if (cmd.emit) begin
			o_drive_q  <= drive_q;
			o_pin_q    <= pin_q;
			o_cvalid_q <= cvalid_q;
			o_cval_q   <= cval_q;
			o_duty_q   <= present_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.is_set    = (action_q == ACT_SET);
	assign sts.at_goal   = (present_q == goal_q);
	assign sts.slot_free = !out_valid_q || out_ready;

	assign out_valid         = out_valid_q;
	assign out_drive_valid   = o_drive_q;
	assign out_direction_pin = o_pin_q;
	assign out_compare_valid = o_cvalid_q;
	assign out_compare_value = o_cval_q;
	assign out_current_duty  = o_duty_q;

endmodule

>>> tb/tb_motor_pwm_ramp_controller.sv
// Self-checking testbench for the motor PWM ramp controller.
module tb_motor_pwm_ramp_controller;
	import mprc_pkg::*;

	// Run shape
	localparam int unsigned RAND_PHASES = 8;
	localparam int unsigned PHASE_WORDS = 166;
	localparam int unsigned LONG_HOLD   = 300;  // result side held off this long, once
	localparam int unsigned SETTLE      = 8;    // extra wait after the last result comes back
	localparam int unsigned STALL_LIMIT = 3000; // cycles with no word moving
	localparam int unsigned DIR_ROWS    = 26;

	// Above the knee the ramp runs this many times faster
	localparam logic [FRATE_W-1:0] FAST_MUL = 11'd5;

	// One input word, laid out like the item channel payload
	typedef struct packed {
		action_t           action;
		logic              dir;
		logic [DUTY_W-1:0] tgt;
		logic [TIME_W-1:0] now;
	} in_word_t;

	// One result word, laid out like the result channel payload
	typedef struct packed {
		logic                drive_valid;
		logic                direction_pin;
		logic                compare_valid;
		logic [RELOAD_W-1:0] compare_value;
		logic [DUTY_W-1:0]   current_duty;
	} word_result_t;

	// Directed row: optional register set-up (applied while idle), the word,
	// and a hand-written result where it is obvious; other rows use the predictor.
	typedef struct {
		bit           do_cfg;
		cfg_t         cfg;
		in_word_t     word;
		bit           typed;
		word_result_t res;
	} directed_row_t;

	localparam cfg_t         CFG_NONE = '0;
	localparam word_result_t NO_CHECK = '0;
	localparam cfg_idx_t     REG_ORDER [4] = '{REG_REVERSED, REG_RELOAD, REG_RATE, REG_DUTY_MAX};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mprc_in_if  item_if ();
	mprc_out_if result_if ();

	motor_pwm_ramp_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_if),
		.result    (result_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor state: ramp state plus a shadow of the registers
	logic [DUTY_W-1:0]   duty_m;
	logic [DUTY_W-1:0]   goal_duty_m;
	logic                goal_dir_m;
	logic [TIME_W-1:0]   t0_m;
	logic [DUTY_W-1:0]   duty0_m;
	logic                rev_c;
	logic [RELOAD_W-1:0] reload_c;
	logic [RATE_W-1:0]   rate_c;
	logic [DUTY_W-1:0]   dmax_c;

	word_result_t pending_results [$];

	int unsigned n_words    = 0;
	int unsigned n_results  = 0;
	int unsigned n_drive    = 0;
	int unsigned n_compare  = 0;
	int unsigned n_settings = 0;
	int unsigned errors     = 0;

	// Idle control shared with the result-side process
	bit src_idle_on = 1'b1;
	bit snk_idle_on = 1'b1;
	bit hold_req    = 1'b0;

	directed_row_t directed_rows [DIR_ROWS] = '{
		// reset defaults: update with nothing to do
		'{1'b0, CFG_NONE, '{ACT_UPDATE, 1'b0, 7'd0, 32'd0},
			1'b1, '{1'b0, 1'b0, 1'b0, 16'd0, 7'd0}},
		'{1'b0, CFG_NONE, '{ACT_SET, 1'b0, 7'd100, 32'd1000},
			1'b1, '{1'b0, 1'b0, 1'b0, 16'd0, 7'd0}},
		// zero elapsed: forward, full inverted compare
		'{1'b0, CFG_NONE, '{ACT_UPDATE, 1'b1, 7'd0, 32'd1000},
			1'b1, '{1'b1, 1'b1, 1'b1, 16'hFFFF, 7'd0}},
		// timestamp wrap gives a huge elapsed time, clamps to target
		'{1'b0, CFG_NONE, '{ACT_UPDATE, 1'b0, 7'd127, 32'd999},
			1'b1, '{1'b1, 1'b1, 1'b1, 16'd0, 7'd100}},
		// already at target: nothing driven
		'{1'b0, CFG_NONE, '{ACT_UPDATE, 1'b1, 7'd55, 32'd12345},
			1'b1, '{1'b0, 1'b0, 1'b0, 16'd0, 7'd100}},
		// direction change zeroes the duty
		'{1'b0, CFG_NONE, '{ACT_SET, 1'b1, 7'd50, 32'd5},
			1'b1, '{1'b0, 1'b0, 1'b0, 16'd0, 7'd0}},
		'{1'b0, CFG_NONE, '{ACT_UPDATE, 1'b0, 7'd0, 32'd205}, 1'b0, NO_CHECK},
		'{1'b0, CFG_NONE, '{ACT_UPDATE, 1'b0, 7'd0, 32'd1005}, 1'b0, NO_CHECK},
		// same direction keeps the duty
		'{1'b0, CFG_NONE, '{ACT_SET, 1'b1, 7'd10, 32'd2000},
			1'b1, '{1'b0, 1'b0, 1'b0, 16'd0, 7'd50}},
		// lower target: jumps down at once
		'{1'b0, CFG_NONE, '{ACT_UPDATE, 1'b1, 7'd0, 32'd2000}, 1'b0, NO_CHECK},
		'{1'b0, CFG_NONE, '{ACT_SET, 1'b0, 7'd127, 32'd0},
			1'b1, '{1'b0, 1'b0, 1'b0, 16'd0, 7'd0}},
		// duty above one hundred on the inverted side: compare withheld
		'{1'b0, CFG_NONE, '{ACT_UPDATE, 1'b0, 7'd0, 32'hFFFF_FFFF},
			1'b1, '{1'b1, 1'b1, 1'b0, 16'd0, 7'd127}},
		// reversed wiring, duty_max at the 7-bit top
		'{1'b1, '{1'b1, 16'hFFFF, 8'd1, 7'd127}, '{ACT_SET, 1'b1, 7'd0, 32'd0},
			1'b1, '{1'b0, 1'b0, 1'b0, 16'd0, 7'd0}},
		'{1'b0, CFG_NONE, '{ACT_SET, 1'b0, 7'd127, 32'd0},
			1'b1, '{1'b0, 1'b0, 1'b0, 16'd0, 7'd0}},
		// reload * 127 / 100 overflows 16 bits: saturates
		'{1'b0, CFG_NONE, '{ACT_UPDATE, 1'b1, 7'd3, 32'hFFFF_FFFF},
			1'b1, '{1'b1, 1'b0, 1'b1, 16'hFFFF, 7'd127}},
		// all-zero reload and duty_max, fastest rate
		'{1'b1, '{1'b0, 16'd0, 8'd255, 7'd0}, '{ACT_SET, 1'b1, 7'd100, 32'd7},
			1'b1, '{1'b0, 1'b0, 1'b0, 16'd0, 7'd0}},
		'{1'b0, CFG_NONE, '{ACT_UPDATE, 1'b0, 7'd0, 32'd7},
			1'b1, '{1'b1, 1'b0, 1'b1, 16'd0, 7'd0}},
		// above duty_max: pin driven, compare withheld
		'{1'b0, CFG_NONE, '{ACT_UPDATE, 1'b0, 7'd0, 32'd8},
			1'b1, '{1'b1, 1'b0, 1'b0, 16'd0, 7'd25}},
		// at the knee, then past it (fast rate)
		'{1'b0, CFG_NONE, '{ACT_UPDATE, 1'b0, 7'd0, 32'd9}, 1'b0, NO_CHECK},
		'{1'b0, CFG_NONE, '{ACT_UPDATE, 1'b0, 7'd0, 32'd10}, 1'b0, NO_CHECK},
		// zero rate: ramp stalls at its start duty
		'{1'b1, '{1'b1, 16'd1000, 8'd0, 7'd100}, '{ACT_SET, 1'b0, 7'd60, 32'd50},
			1'b1, '{1'b0, 1'b0, 1'b0, 16'd0, 7'd0}},
		'{1'b0, CFG_NONE, '{ACT_UPDATE, 1'b0, 7'd0, 32'd100000}, 1'b0, NO_CHECK},
		// reversed backward: inverted side
		'{1'b1, '{1'b1, 16'd12345, 8'd10, 7'd50}, '{ACT_SET, 1'b1, 7'd80, 32'd0},
			1'b1, '{1'b0, 1'b0, 1'b0, 16'd0, 7'd0}},
		'{1'b0, CFG_NONE, '{ACT_UPDATE, 1'b0, 7'd0, 32'd100}, 1'b0, NO_CHECK},
		'{1'b0, CFG_NONE, '{ACT_SET, 1'b1, 7'd30, 32'd500}, 1'b0, NO_CHECK},
		'{1'b0, CFG_NONE, '{ACT_UPDATE, 1'b0, 7'd0, 32'd500}, 1'b0, NO_CHECK}
	};

	// Predicts the result of one word and advances the shadow ramp state.
	function automatic word_result_t ramp_and_scale(input in_word_t w);
		logic [FRATE_W-1:0] eff_rate;
		logic [TIME_W-1:0]  elapsed;
		logic [63:0]        ramped;
		logic [DUTY_W-1:0]  adj;
		logic               negative;
		logic [31:0]        quotient;
		word_result_t       r;
		r = '0;
		if (w.action == ACT_SET) begin
			goal_duty_m = w.tgt;
			if (w.dir != goal_dir_m) begin
				duty_m = '0;
			end
			goal_dir_m = w.dir;
			t0_m = w.now;
			duty0_m = duty_m;
		end else if (duty_m != goal_duty_m) begin
			eff_rate = (duty_m > SPEED_KNEE) ? FRATE_W'(rate_c) * FAST_MUL : FRATE_W'(rate_c);
			elapsed = w.now - t0_m;
			// full-width product, no 32-bit wrap
			ramped = 64'(eff_rate) * 64'(elapsed) / 64'(TIME_DIV) + 64'(duty0_m);
			if (ramped >= 64'(goal_duty_m)) begin
				ramped = 64'(goal_duty_m);
			end
			duty_m = ramped[DUTY_W-1:0];
			r.drive_valid = 1'b1;
			// the inverted side is always the one whose pin level is 1
			r.direction_pin = rev_c ? goal_dir_m : ~goal_dir_m;
			negative = r.direction_pin && (duty_m > PERCENT);
			adj = r.direction_pin ? PERCENT - duty_m : duty_m;
			if (!negative && adj <= dmax_c) begin
				quotient = 32'(reload_c) * 32'(adj) / 32'(PERCENT);
				r.compare_valid = 1'b1;
				r.compare_value = (quotient > 32'hFFFF) ? 16'hFFFF : quotient[RELOAD_W-1:0];
			end
		end
		r.current_duty = duty_m;
		return r;
	endfunction

	// Idle length: mostly short, now and then long.
	function automatic int unsigned idle_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) return $urandom_range(0, 2);
		if (roll < 95) return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	// Offers one word after an optional gap, waits for it to be taken,
	// then queues what it should produce.
	task automatic send_word(input in_word_t w, input bit typed, input word_result_t typed_res);
		word_result_t pred;
		int unsigned gap;
		gap = src_idle_on ? idle_len() : 0;
		if (gap != 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_if.valid       <= 1'b1;
		item_if.action      <= w.action;
		item_if.direction   <= w.dir;
		item_if.target_duty <= w.tgt;
		item_if.now_ms      <= w.now;
		do @(posedge clk); while (item_if.ready !== 1'b1);
		pred = ramp_and_scale(w);
		pending_results.push_back(typed ? typed_res : pred);
		n_words++;
	endtask

	// Stops offering and waits for every queued word to come back.
	task automatic drain_results();
		item_if.valid <= 1'b0;
		while (n_results < n_words) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Writes all four registers, one per edge; only called while idle.
	task automatic set_config(input cfg_t c);
		foreach (REG_ORDER[k]) begin
			cfg_we    <= 1'b1;
			cfg_index <= REG_ORDER[k];
			case (REG_ORDER[k])
				REG_REVERSED: begin
					cfg_data <= CFG_DATA_W'(c.reversed_wiring);
					rev_c = c.reversed_wiring;
				end
				REG_RELOAD: begin
					cfg_data <= CFG_DATA_W'(c.timer_reload);
					reload_c = c.timer_reload;
				end
				REG_RATE: begin
					cfg_data <= CFG_DATA_W'(c.ramp_rate);
					rate_c = c.ramp_rate;
				end
				REG_DUTY_MAX: begin
					cfg_data <= CFG_DATA_W'(c.duty_max);
					dmax_c = c.duty_max;
				end
				default: begin
					cfg_data <= '0;
				end
			endcase
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] seen);
		if (want !== seen) begin
			errors++;
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, seen);
		end
	endtask

	// Result side: compare every taken word with the oldest expectation.
	always @(posedge clk) begin : result_check
		word_result_t got;
		word_result_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			got.drive_valid   = result_if.drive_valid;
			got.direction_pin = result_if.direction_pin;
			got.compare_valid = result_if.compare_valid;
			got.compare_value = result_if.compare_value;
			got.current_duty  = result_if.current_duty;
			n_results++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result word with nothing expected: expected none, got %h",
					$time, got);
			end else begin
				want = pending_results.pop_front();
				check_field("drive_valid", 32'(want.drive_valid), 32'(got.drive_valid));
				check_field("direction_pin", 32'(want.direction_pin), 32'(got.direction_pin));
				check_field("compare_valid", 32'(want.compare_valid), 32'(got.compare_valid));
				check_field("compare_value", 32'(want.compare_value), 32'(got.compare_value));
				check_field("current_duty", 32'(want.current_duty), 32'(got.current_duty));
				if (got.drive_valid === 1'b1) n_drive++;
				if (got.compare_valid === 1'b1) n_compare++;
			end
		end
	end

	// Result-side ready: random gaps, plus one long hold-off on request,
	// counted here while the sender keeps offering.
	initial begin : result_sink
		int unsigned gap_left;
		int unsigned hold_left;
		gap_left  = 0;
		hold_left = 0;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				result_if.ready <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = LONG_HOLD - 1;
				result_if.ready <= 1'b0;
			end else if (gap_left != 0) begin
				result_if.ready <= 1'b0;
				gap_left--;
			end else begin
				result_if.ready <= 1'b1;
				if (snk_idle_on && $urandom_range(0, 2) == 0) gap_left = idle_len();
			end
		end
	end

	// Watchdog: ends the run if no word moves on either channel for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (item_if.valid && item_if.ready)
					|| (result_if.valid && result_if.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Main sequence: reset, directed table, then random phases per setting.
	initial begin : stimulus
		in_word_t    w;
		cfg_t        c;
		int unsigned roll;
		logic [TIME_W-1:0] ms;
		logic        dir_now;

		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_index           <= REG_REVERSED;
		cfg_data            <= '0;
		item_if.valid       <= 1'b0;
		item_if.action      <= ACT_SET;
		item_if.direction   <= 1'b0;
		item_if.target_duty <= '0;
		item_if.now_ms      <= '0;

		// shadow state and registers at their reset values
		duty_m      = '0;
		goal_duty_m = '0;
		goal_dir_m  = 1'b0;
		t0_m        = '0;
		duty0_m     = '0;
		rev_c       = 1'b0;
		reload_c    = RELOAD_RST;
		rate_c      = RATE_RST;
		dmax_c      = DUTY_MAX_RST;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part; register changes only after the pipe has drained
		foreach (directed_rows[r]) begin
			if (directed_rows[r].do_cfg) begin
				drain_results();
				set_config(directed_rows[r].cfg);
			end
			send_word(directed_rows[r].word, directed_rows[r].typed, directed_rows[r].res);
		end
		drain_results();

		// random part: mostly ramp sequences (set, then updates with a
		// steadily advancing clock), some noise and broken sequences
		dir_now = 1'b0;
		for (int unsigned p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: c = '{1'b0, 16'h0000, 8'h00, 7'd0};
				1: c = '{1'b1, 16'hFFFF, 8'hFF, 7'd100};
				default: begin
					c.reversed_wiring = 1'($urandom_range(0, 1));
					c.timer_reload = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
					c.ramp_rate = 8'($urandom_range(1, 24));
					c.duty_max = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 100))
						: 7'($urandom_range(60, 100));
				end
			endcase
			set_config(c);
			src_idle_on = (p % 3) != 1;
			snk_idle_on = (p % 4) != 3;
			// one phase starts just short of the millisecond wrap
			ms = (p == 1) ? 32'hFFFF_FF00 : $urandom();

			for (int unsigned i = 0; i < PHASE_WORDS; i++) begin
				if (p == 2 && i == 40) hold_req = 1'b1;
				// sender pause until everything is back, mid-phase
				if (p == 3 && i == 80) drain_results();

				roll  = $urandom_range(0, 99);
				w.dir = 1'($urandom_range(0, 1));
				w.tgt = 7'($urandom_range(0, 127));
				if (roll < 12) begin
					w.action = ACT_SET;
					if ($urandom_range(0, 3) == 0) dir_now = ~dir_now;
					w.dir = dir_now;
					w.tgt = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(101, 127))
						: 7'($urandom_range(0, 100));
					ms = ms + $urandom_range(0, 5);
					w.now = ms;
				end else if (roll < 17) begin
					// noise: any action, any timestamp
					w.action = action_t'($urandom_range(0, 1));
					w.now = $urandom();
				end else begin
					w.action = ACT_UPDATE;
					ms = ms + (($urandom_range(0, 9) == 0) ? $urandom_range(100, 5000)
						: $urandom_range(0, 40));
					w.now = ms;
				end
				send_word(w, 1'b0, NO_CHECK);
			end
			drain_results();
		end

		if (pending_results.size() != 0) begin
			errors++;
			$display("%0t: words left without result: expected 0, got %0d",
				$time, pending_results.size());
		end

		$display("Sent %0d words under %0d register settings, %0d results checked;",
			n_words, n_settings, n_results);
		$display("%0d drove the pins and %0d wrote a compare value.", n_drive, n_compare);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> filelist.f
design/mprc_pkg.sv
design/mprc_if.sv
design/mprc_cfg.sv
design/mprc_ctrl.sv
design/mprc_dp.sv
design/motor_pwm_ramp_controller.sv
tb/tb_motor_pwm_ramp_controller.sv
